>>> sv/prb_pkg.sv
// ----------------------------------------------------------------------------
// prb_pkg
// Shared types and constants for the packet reorder buffer receiver.
// ----------------------------------------------------------------------------
package prb_pkg;

  localparam int SEQ_W  = 32;
  localparam int SIZE_W = 4;
  localparam int PAY_W  = 64;
  localparam int KIND_W = 3;

  typedef enum logic [KIND_W-1:0] {
    K_DELIVERED = 3'd0,
    K_STORED    = 3'd1,
    K_DROPPED   = 3'd2,
    K_DRAINED   = 3'd3,
    K_IGNORED   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_EMIT,
    ST_FLUSH
  } state_t;

  // normalised packet handed from front to back
  typedef struct packed {
    logic              channel;
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [PAY_W-1:0]  payload;
    logic              is_short;
  } item_t;

  // one result entry
  typedef struct packed {
    kind_t             kind;
    logic              ack_channel;
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [PAY_W-1:0]  payload;
    logic              last;
  } res_t;

  // contents of one reorder slot
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [PAY_W-1:0]  payload;
  } slot_data_t;

endpackage

>>> sv/prb_ram.sv
// ----------------------------------------------------------------------------
// prb_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module prb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> sv/prb_front.sv
// ----------------------------------------------------------------------------
// prb_front
// Input side: holds the full size register, normalises each packet and
// queues it in a two entry buffer for the back end.
// ----------------------------------------------------------------------------
module prb_front #(
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [prb_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_channel,
  input  logic [prb_pkg::SEQ_W-1:0]   in_seq,
  input  logic [prb_pkg::SIZE_W-1:0]  in_size,
  input  logic [prb_pkg::PAY_W-1:0]   in_payload,
  output logic                        item_valid,
  output prb_pkg::item_t              item,
  input  logic                        item_take
);
  import prb_pkg::*;

  localparam logic [SIZE_W-1:0] MaxSize = SIZE_W'(PAYLOAD_BYTES);
  localparam logic [PAY_W-1:0]  PayMask = {PAY_W{1'b1}} >> (PAY_W - 8 * PAYLOAD_BYTES);

  logic [SIZE_W-1:0] full_size_r;
  item_t             q_r [2];
  logic              wr_ptr_r;
  logic              rd_ptr_r;
  logic [1:0]        cnt_r;
  logic [1:0]        cnt_nxt;
  logic              wr_en;
  logic              rd_en;
  item_t             norm;

  always_comb begin
    norm.channel  = in_channel;
    norm.seq      = in_seq;
    norm.size     = (in_size > MaxSize) ? MaxSize : in_size;
    norm.payload  = in_payload & PayMask;
    norm.is_short = (norm.size != full_size_r);
  end

  assign full       = (cnt_r == 2'd2);
  assign wr_en      = push && !full;
  assign item_valid = (cnt_r != 2'd0);
  assign rd_en      = item_take && item_valid;
  assign item       = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_size_r <= SIZE_W'(8);
      wr_ptr_r    <= 1'b0;
      rd_ptr_r    <= 1'b0;
      cnt_r       <= 2'd0;
    end else begin
      if (cfg_we) begin
        full_size_r <= cfg_data;
      end
      if (wr_en) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (rd_en) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= norm;
    end
  end

endmodule

>>> sv/prb_back.sv
// ----------------------------------------------------------------------------
// prb_back
// Back end sequencer: in-order check, slot store with parallel tag match,
// drain of matching slots and result generation into the output queue.
// ----------------------------------------------------------------------------
module prb_back #(
  parameter int SLOTS = 16,
  parameter int LEN_W = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  input  prb_pkg::item_t item,
  output logic           item_take,
  input  logic           room,
  output logic           res_we,
  output prb_pkg::res_t  res_data,
  output logic           commit_r,
  output logic [LEN_W-1:0] commit_len_r,
  output logic           commit_done_r
);
  import prb_pkg::*;

  localparam int SI_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  state_t             state_r, state_nxt;
  logic [SEQ_W-1:0]   exp_r, exp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               fin_r, fin_nxt;
  logic [SLOTS-1:0]   valid_r, valid_nxt;
  logic [SEQ_W-1:0]   tag_r [SLOTS];
  res_t               pend_r, pend_nxt;
  logic [SEQ_W-1:0]   cur_seq_r, cur_seq_nxt;
  logic [SIZE_W-1:0]  cur_size_r, cur_size_nxt;
  logic               cur_short_r, cur_short_nxt;
  logic               ignore_r, ignore_nxt;
  logic [LEN_W-1:0]   run_len_r, run_len_nxt;
  logic               commit_nxt;
  logic [LEN_W-1:0]   commit_len_nxt;
  logic               commit_done_nxt;

  logic [SI_W-1:0]    free_idx;
  logic [SI_W-1:0]    hit_idx;
  logic               hit_any;
  logic [SLOTS-1:0]   match;
  logic               slot_we;
  slot_data_t         slot_wdata;
  slot_data_t         slot_rdata;

  always_comb begin
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = SI_W'(i);
      end
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == exp_r);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = SI_W'(i);
      end
    end
    hit_any = |match;
  end

  assign slot_wdata.size    = item.size;
  assign slot_wdata.payload = item.payload;

  prb_ram #(
    .WIDTH ($bits(slot_data_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .we      (slot_we),
    .waddr   (free_idx),
    .wdata   (slot_wdata),
    .raddr   (hit_idx),
    .rdata_r (slot_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    exp_nxt         = exp_r;
    cnt_nxt         = cnt_r;
    fin_nxt         = fin_r;
    valid_nxt       = valid_r;
    pend_nxt        = pend_r;
    cur_seq_nxt     = cur_seq_r;
    cur_size_nxt    = cur_size_r;
    cur_short_nxt   = cur_short_r;
    ignore_nxt      = ignore_r;
    run_len_nxt     = run_len_r;
    commit_nxt      = 1'b0;
    commit_len_nxt  = commit_len_r;
    commit_done_nxt = commit_done_r;
    item_take       = 1'b0;
    slot_we         = 1'b0;
    res_we          = 1'b0;
    res_data        = pend_r;

    unique case (state_r)
      ST_IDLE: begin
        if (item_valid && room) begin
          item_take        = 1'b1;
          run_len_nxt      = '0;
          cur_seq_nxt      = item.seq;
          cur_size_nxt     = item.size;
          cur_short_nxt    = item.is_short;
          ignore_nxt       = fin_r;
          pend_nxt.ack_channel = 1'b0;
          pend_nxt.seq     = item.seq;
          pend_nxt.size    = '0;
          pend_nxt.payload = '0;
          pend_nxt.last    = 1'b0;
          state_nxt        = ST_FLUSH;
          if (fin_r) begin
            pend_nxt.kind = K_IGNORED;
          end else if (item.seq == exp_r) begin
            pend_nxt.kind        = K_DELIVERED;
            pend_nxt.ack_channel = item.channel;
            pend_nxt.size        = item.size;
            pend_nxt.payload     = item.payload;
            exp_nxt              = exp_r + SEQ_W'(item.size);
            if (cnt_r != '0) begin
              state_nxt = ST_MATCH;
            end
          end else if (cnt_r == CNT_W'(SLOTS)) begin
            pend_nxt.kind = K_DROPPED;
          end else begin
            pend_nxt.kind        = K_STORED;
            pend_nxt.ack_channel = item.channel;
            slot_we              = 1'b1;
            valid_nxt[free_idx]  = 1'b1;
            cnt_nxt              = cnt_r + CNT_W'(1);
          end
        end
      end
      ST_MATCH: begin
        if (hit_any) begin
          res_we              = 1'b1;
          run_len_nxt         = run_len_r + LEN_W'(1);
          valid_nxt[hit_idx]  = 1'b0;
          cnt_nxt             = cnt_r - CNT_W'(1);
          pend_nxt.seq        = exp_r;
          state_nxt           = ST_EMIT;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_EMIT: begin
        pend_nxt.kind        = K_DRAINED;
        pend_nxt.ack_channel = 1'b0;
        pend_nxt.size        = slot_rdata.size;
        pend_nxt.payload     = slot_rdata.payload;
        exp_nxt              = exp_r + SEQ_W'(slot_rdata.size);
        state_nxt            = (cnt_r == '0) ? ST_FLUSH : ST_MATCH;
      end
      ST_FLUSH: begin
        res_we          = 1'b1;
        res_data.last   = 1'b1;
        commit_nxt      = 1'b1;
        commit_len_nxt  = run_len_r + LEN_W'(1);
        if (ignore_r) begin
          commit_done_nxt = 1'b1;
        end else begin
          commit_done_nxt = cur_short_r && (exp_r == cur_seq_r + SEQ_W'(cur_size_r));
        end
        fin_nxt   = commit_done_nxt;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      exp_r    <= '0;
      cnt_r    <= '0;
      fin_r    <= 1'b0;
      valid_r  <= '0;
      commit_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      exp_r    <= exp_nxt;
      cnt_r    <= cnt_nxt;
      fin_r    <= fin_nxt;
      valid_r  <= valid_nxt;
      commit_r <= commit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      tag_r[free_idx] <= item.seq;
    end
    pend_r        <= pend_nxt;
    cur_seq_r     <= cur_seq_nxt;
    cur_size_r    <= cur_size_nxt;
    cur_short_r   <= cur_short_nxt;
    ignore_r      <= ignore_nxt;
    run_len_r     <= run_len_nxt;
    commit_len_r  <= commit_len_nxt;
    commit_done_r <= commit_done_nxt;
  end

endmodule

>>> sv/prb_outq.sv
// ----------------------------------------------------------------------------
// prb_outq
// Result queue: entries of a packet become visible together once the
// packet's run is complete; tracks which waiting entries see done.
// ----------------------------------------------------------------------------
module prb_outq #(
  parameter int SLOTS = 16,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_we,
  input  prb_pkg::res_t res_data,
  input  logic          commit,
  input  logic [AW:0]   commit_len,
  input  logic          commit_done,
  output logic          room,
  output logic          empty,
  input  logic          pop,
  output prb_pkg::res_t head,
  output logic          head_done
);
  import prb_pkg::*;

  localparam int DEPTH = 2 ** AW;
  localparam logic [AW:0] RoomMax = (AW + 1)'(DEPTH - SLOTS - 1);

  logic [AW-1:0] wptr_r;
  logic [AW-1:0] rptr_r;
  logic [AW-1:0] raddr;
  logic [AW:0]   occ_r, occ_nxt;
  logic [AW:0]   ccnt_r, ccnt_nxt;
  logic [AW:0]   undone_r, undone_nxt;
  logic          do_pop;
  logic [$bits(res_t)-1:0] rdata;

  assign empty     = (ccnt_r == '0);
  assign do_pop    = pop && !empty;
  assign room      = (occ_r <= RoomMax);
  assign raddr     = do_pop ? rptr_r + AW'(1) : rptr_r;
  assign head      = res_t'(rdata);
  assign head_done = (undone_r == '0);

  prb_ram #(
    .WIDTH ($bits(res_t)),
    .DEPTH (DEPTH)
  ) u_res_ram (
    .clk     (clk),
    .we      (res_we),
    .waddr   (wptr_r),
    .wdata   (res_data),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  always_comb begin
    occ_nxt    = occ_r + (AW + 1)'(res_we) - (AW + 1)'(do_pop);
    ccnt_nxt   = ccnt_r - (AW + 1)'(do_pop);
    undone_nxt = undone_r;
    if (do_pop && (undone_r != '0)) begin
      undone_nxt = undone_r - (AW + 1)'(1);
    end
    if (commit) begin
      ccnt_nxt = ccnt_nxt + commit_len;
      if (!commit_done) begin
        undone_nxt = undone_nxt + commit_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r   <= '0;
      rptr_r   <= '0;
      occ_r    <= '0;
      ccnt_r   <= '0;
      undone_r <= '0;
    end else begin
      if (res_we) begin
        wptr_r <= wptr_r + AW'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + AW'(1);
      end
      occ_r    <= occ_nxt;
      ccnt_r   <= ccnt_nxt;
      undone_r <= undone_nxt;
    end
  end

endmodule

>>> sv/packet_reorder_buffer_receiver.sv
// ----------------------------------------------------------------------------
// packet_reorder_buffer_receiver
// Receive side reorder buffer: acks, delivers, stores and drains packets.
// ----------------------------------------------------------------------------
// visibility: results of a packet become visible after the back end steps
//   through match and emit for each drained packet, then flush and commit
// throughput: the back end takes a new packet only when idle, after the flush
//   of the last one; each drain is a slot tag match, then a registered RAM read
// reset: synchronous; clears control state, slot valid bits and queues,
//   full size returns to 8; slot contents stay undefined until written
module packet_reorder_buffer_receiver #(
  parameter int SLOTS         = 16,
  parameter int PAYLOAD_BYTES = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [prb_pkg::SIZE_W-1:0]  cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_channel,
  input  logic [prb_pkg::SEQ_W-1:0]   in_seq,
  input  logic [prb_pkg::SIZE_W-1:0]  in_size,
  input  logic [prb_pkg::PAY_W-1:0]   in_payload,
  output logic                        empty,
  input  logic                        pop,
  output logic [prb_pkg::KIND_W-1:0]  out_kind,
  output logic                        out_ack_channel,
  output logic [prb_pkg::SEQ_W-1:0]   out_seq,
  output logic [prb_pkg::SIZE_W-1:0]  out_size,
  output logic [prb_pkg::PAY_W-1:0]   out_payload,
  output logic                        out_last_of_run,
  output logic                        out_done_res
);
  import prb_pkg::*;

  localparam int AW = $clog2(SLOTS + 1) + 1;

  logic          item_valid;
  item_t         item;
  logic          item_take;
  logic          room;
  logic          res_we;
  res_t          res_data;
  logic          commit;
  logic [AW:0]   commit_len;
  logic          commit_done;
  res_t          head;

  prb_front #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .push       (push),
    .full       (full),
    .in_channel (in_channel),
    .in_seq     (in_seq),
    .in_size    (in_size),
    .in_payload (in_payload),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  prb_back #(
    .SLOTS (SLOTS),
    .LEN_W (AW + 1)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .room          (room),
    .res_we        (res_we),
    .res_data      (res_data),
    .commit_r      (commit),
    .commit_len_r  (commit_len),
    .commit_done_r (commit_done)
  );

  prb_outq #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .res_we      (res_we),
    .res_data    (res_data),
    .commit      (commit),
    .commit_len  (commit_len),
    .commit_done (commit_done),
    .room        (room),
    .empty       (empty),
    .pop         (pop),
    .head        (head),
    .head_done   (out_done_res)
  );

  assign out_kind        = head.kind;
  assign out_ack_channel = head.ack_channel;
  assign out_seq         = head.seq;
  assign out_size        = head.size;
  assign out_payload     = head.payload;
  assign out_last_of_run = head.last;

endmodule
